// File: hdl/http_request_head_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// http request head tokenizer assertion macros
// shared concurrent check forms for the tokenizer rtl
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_MACROS_SVH

// check that is skipped while reset is asserted
`define HRHT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds during reset
`define HRHT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/hrht_pkg.sv
// ----------------------------------------------------------------------------
// hrht_pkg
// types and constants of the http request head tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package hrht_pkg;

    typedef enum logic [2:0] {
        PH_METHOD   = 3'd0,
        PH_PATH     = 3'd1,
        PH_QUERY    = 3'd2,
        PH_PROTOCOL = 3'd3,
        PH_KEY      = 3'd4,
        PH_VALUE    = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    // token kinds
    localparam logic [2:0] K_METHOD   = 3'd0;
    localparam logic [2:0] K_PATH     = 3'd1;
    localparam logic [2:0] K_QUERY    = 3'd2;
    localparam logic [2:0] K_PROTOCOL = 3'd3;
    localparam logic [2:0] K_KEY      = 3'd4;
    localparam logic [2:0] K_VALUE    = 3'd5;
    localparam logic [2:0] K_LINE_END = 3'd6;
    localparam logic [2:0] K_STATUS   = 3'd7;

    // head status codes
    localparam logic [2:0] ST_OK                = 3'd0;
    localparam logic [2:0] ST_NO_START_NEWLINE  = 3'd1;
    localparam logic [2:0] ST_NO_START_SPACE    = 3'd2;
    localparam logic [2:0] ST_NO_HEADER_NEWLINE = 3'd3;
    localparam logic [2:0] ST_NO_COLON          = 3'd4;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_COLON = 8'h3a;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic [7:0] head_byte;
        logic       end_of_head;
    } in_item_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] token_char;
        logic       token_first;
        logic [2:0] head_status;
        logic       head_done;
    } out_item_t;

    typedef struct packed {
        phase_t parse_phase;
        logic   token_has_char;
        logic   line_has_char;
        logic   query_seen;
    } parse_state_t;

endpackage

`default_nettype wire

// File: hdl/http_request_head_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_head_tokenizer
// tags each byte of an http request head with its token kind
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | item
//  ---------+-----------+-------------------------+---------------------------
//  byte     | in        | byte_valid / byte_stall | head_byte, end_of_head
//  token    | out       | token_valid/token_stall | kind, char, first, status
//
//  a byte is held in the input register, then parsed combinationally, and
//  its 0 to 3 token items enter a four-entry result queue
//  one token item leaves per cycle while token_stall is low, so the byte rate is
//  one per cycle while bytes give at most one item each, and bytes giving more
//  stall the byte side until the queue drains (the queue output port sets this)
//  a byte is parsed only when the queue holds at most one item
//  asynchronous active-low reset clears the parse state and empties the queue
//  token_stall never reaches byte_stall in the same cycle
//
`default_nettype none

`include "http_request_head_tokenizer_macros.svh"

module http_request_head_tokenizer
    import hrht_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_item,
    output logic           token_valid,
    input  wire logic      token_stall,
    output out_item_t      token_item
);

    // result of feeding one content character through the parser
    typedef struct packed {
        parse_state_t st;
        logic         hit;
        logic [2:0]   kind;
        logic [7:0]   ch;
        logic         first;
    } content_res_t;

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic out_item_t mk_item(logic [2:0] kind, logic [7:0] ch, logic first,
                                          logic [2:0] status, logic done);
        out_item_t it;
        it.token_kind  = kind;
        it.token_char  = ch;
        it.token_first = first;
        it.head_status = status;
        it.head_done   = done;
        return it;
    endfunction

    // one content character: phase move or one tagged character
    function automatic content_res_t content_fn(parse_state_t s, logic [7:0] c);
        content_res_t r;
        r.st    = s;
        r.hit   = 1'b0;
        r.kind  = K_METHOD;
        r.ch    = c;
        r.first = 1'b0;
        case (s.parse_phase)
            PH_METHOD:
            begin
                if (c == CH_SP)
                begin
                    r.st.parse_phase    = PH_PATH;
                    r.st.token_has_char = 1'b0;
                end
                else
                begin
                    r.hit  = 1'b1;
                    r.kind = K_METHOD;
                    r.ch   = to_upper(c);
                end
            end
            PH_PATH:
            begin
                if (c == CH_SP)
                begin
                    r.st.parse_phase    = PH_PROTOCOL;
                    r.st.token_has_char = 1'b0;
                end
                else if (c == CH_QMARK && s.token_has_char && !s.query_seen)
                begin
                    // query starts and keeps its marker
                    r.st.parse_phase    = PH_QUERY;
                    r.st.query_seen     = 1'b1;
                    r.st.token_has_char = 1'b0;
                    r.hit               = 1'b1;
                    r.kind              = K_QUERY;
                end
                else
                begin
                    if (c == CH_QMARK)
                    begin
                        r.st.query_seen = 1'b1;
                    end
                    r.hit  = 1'b1;
                    r.kind = K_PATH;
                end
            end
            PH_QUERY:
            begin
                if (c == CH_SP)
                begin
                    r.st.parse_phase    = PH_PROTOCOL;
                    r.st.token_has_char = 1'b0;
                end
                else
                begin
                    r.hit  = 1'b1;
                    r.kind = K_QUERY;
                end
            end
            PH_PROTOCOL:
            begin
                r.hit  = 1'b1;
                r.kind = K_PROTOCOL;
                r.ch   = to_upper(c);
            end
            PH_KEY:
            begin
                r.st.line_has_char = 1'b1;
                if (c == CH_COLON)
                begin
                    r.st.parse_phase    = PH_VALUE;
                    r.st.token_has_char = 1'b0;
                end
                else
                begin
                    r.hit  = 1'b1;
                    r.kind = K_KEY;
                    r.ch   = to_lower(c);
                end
            end
            PH_VALUE:
            begin
                r.st.line_has_char = 1'b1;
                r.hit              = 1'b1;
                r.kind             = K_VALUE;
            end
            default:
            begin
                r.hit = 1'b0;
            end
        endcase
        if (r.hit)
        begin
            r.first             = ~r.st.token_has_char;
            r.st.token_has_char = 1'b1;
        end
        return r;
    endfunction

    localparam parse_state_t STATE_RESET = '{
        parse_phase:    PH_METHOD,
        token_has_char: 1'b0,
        line_has_char:  1'b0,
        query_seen:     1'b0
    };

    // input register
    logic     in_vld_reg;
    in_item_t in_data_reg;

    // parse state
    parse_state_t state_reg, state_next;
    logic         cr_pending_reg, cr_pending_next;

    // result queue
    out_item_t            fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   cnt_reg, cnt_next;

    logic         consume;
    logic         pop;
    logic [1:0]   n_res;
    out_item_t    res_list [3];
    content_res_t cr_a, cr_b;
    logic [7:0]   c;

    // parse only when the queue has room for the worst case of three items
    assign consume    = in_vld_reg && (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 3));
    assign byte_stall = in_vld_reg && !consume;
    assign pop        = token_valid && !token_stall;

    assign token_valid = (cnt_reg != '0);
    assign token_item  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_vld_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_data_reg <= byte_item;
        end
    end

    // step logic: a held cr, the byte itself, then end of head
    assign c = in_data_reg.head_byte;

    always_comb
    begin
        state_next      = state_reg;
        cr_pending_next = cr_pending_reg;
        n_res           = 2'd0;
        res_list[0]     = '0;
        res_list[1]     = '0;
        res_list[2]     = '0;
        cr_a            = content_fn(state_reg, CH_CR);
        cr_b            = content_fn(state_reg, c);

        if (state_reg.parse_phase != PH_DONE)
        begin
            if (cr_pending_reg)
            begin
                cr_pending_next = 1'b0;
                if (c == CH_LF)
                begin
                    // line end
                    case (state_reg.parse_phase)
                        PH_METHOD, PH_PATH, PH_QUERY:
                        begin
                            res_list[0] = mk_item(K_STATUS, 8'd0, 1'b0, ST_NO_START_SPACE, 1'b1);
                            n_res       = 2'd1;
                            state_next.parse_phase = PH_DONE;
                        end
                        PH_PROTOCOL, PH_VALUE:
                        begin
                            res_list[0] = mk_item(K_LINE_END, 8'd0, 1'b0, ST_OK, 1'b0);
                            n_res       = 2'd1;
                            state_next.parse_phase    = PH_KEY;
                            state_next.token_has_char = 1'b0;
                            state_next.line_has_char  = 1'b0;
                            state_next.query_seen     = 1'b0;
                        end
                        PH_KEY:
                        begin
                            if (!state_reg.line_has_char)
                            begin
                                // empty line: head complete
                                res_list[0] = mk_item(K_LINE_END, 8'd0, 1'b0, ST_OK, 1'b0);
                                res_list[1] = mk_item(K_STATUS, 8'd0, 1'b0, ST_OK, 1'b1);
                                n_res       = 2'd2;
                            end
                            else
                            begin
                                res_list[0] = mk_item(K_STATUS, 8'd0, 1'b0, ST_NO_COLON, 1'b1);
                                n_res       = 2'd1;
                            end
                            state_next.parse_phase = PH_DONE;
                        end
                        default:
                        begin
                            n_res = 2'd0;
                        end
                    endcase
                end
                else
                begin
                    // lone cr goes out as content ahead of this byte
                    state_next = cr_a.st;
                    if (cr_a.hit)
                    begin
                        res_list[0] = mk_item(cr_a.kind, cr_a.ch, cr_a.first, ST_OK, 1'b0);
                        n_res       = 2'd1;
                    end
                    if (c == CH_CR)
                    begin
                        cr_pending_next = 1'b1;
                    end
                    else
                    begin
                        cr_b       = content_fn(cr_a.st, c);
                        state_next = cr_b.st;
                        if (cr_b.hit)
                        begin
                            res_list[n_res] = mk_item(cr_b.kind, cr_b.ch, cr_b.first,
                                                      ST_OK, 1'b0);
                            n_res           = n_res + 2'd1;
                        end
                    end
                end
            end
            else if (c == CH_CR)
            begin
                cr_pending_next = 1'b1;
            end
            else
            begin
                state_next = cr_b.st;
                if (cr_b.hit)
                begin
                    res_list[0] = mk_item(cr_b.kind, cr_b.ch, cr_b.first, ST_OK, 1'b0);
                    n_res       = 2'd1;
                end
            end
        end

        if (in_data_reg.end_of_head)
        begin
            // early end reports which line was left open
            if (state_next.parse_phase != PH_DONE)
            begin
                res_list[n_res] = mk_item(K_STATUS, 8'd0, 1'b0,
                    (state_next.parse_phase <= PH_PROTOCOL) ? ST_NO_START_NEWLINE
                                                            : ST_NO_HEADER_NEWLINE,
                    1'b1);
                n_res           = n_res + 2'd1;
            end
            state_next      = STATE_RESET;
            cr_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            cr_pending_reg <= 1'b0;
        end
        else if (consume)
        begin
            state_reg      <= state_next;
            cr_pending_reg <= cr_pending_next;
        end
    end

    // queue pointers and fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (consume)
        begin
            cnt_next = FIFO_CW'(cnt_next + FIFO_CW'(n_res));
        end
        if (pop)
        begin
            cnt_next = FIFO_CW'(cnt_next - FIFO_CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (consume)
            begin
                wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + FIFO_AW'(n_res));
            end
            if (pop)
            begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + FIFO_AW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (consume && (i < int'(n_res)))
            begin
                fifo_reg[FIFO_AW'(wr_ptr_reg + FIFO_AW'(i))] <= res_list[i];
            end
        end
    end

    // checks
    `HRHT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (cnt_reg == '0 && !in_vld_reg),
        "reset did not empty the block")
    `HRHT_ASSERT(a_fifo_bound, (cnt_reg <= FIFO_CW'(FIFO_DEPTH)), "result queue overflow")
    `HRHT_ASSERT(a_end_restarts,
        (consume && in_data_reg.end_of_head) |=>
            (state_reg.parse_phase == PH_METHOD && !cr_pending_reg),
        "end of head did not restart parsing")
    `HRHT_ASSERT(a_no_grow_idle, !consume |=> (cnt_reg <= $past(cnt_reg)),
        "queue grew without a parsed byte")
    `HRHT_ASSERT(a_done_silent,
        (consume && state_reg.parse_phase == PH_DONE && !in_data_reg.end_of_head)
            |-> (n_res == 2'd0),
        "items produced after head finished")

endmodule

`default_nettype wire

// File: tb/http_request_head_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_head_tokenizer_tb
// feeds request heads to the tokenizer one byte per item, predicts the token
// items of each byte in a local parser model and checks every token item in
// order; random idling on both sides, a long receiver hold, a paused sender
// and a full-rate tail
// ----------------------------------------------------------------------------

module http_request_head_tokenizer_tb;
    import hrht_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES     = 200;
    localparam int FULL_RATE_BYTES  = 100;

    typedef logic [7:0] byte_q_t[$];

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      token_valid;
    logic      token_stall;
    out_item_t token_item;

    // parser model state
    phase_t parse_ph;
    logic   cr_held;
    logic   tok_started;
    logic   line_started;
    logic   qmark_seen;

    // token items still owed by the block, oldest first
    out_item_t pending_tokens[$];
    out_item_t token_want;

    int   errors         = 0;
    int   bytes_sent     = 0;
    int   tokens_checked = 0;
    int   heads_ok       = 0;
    int   heads_bad      = 0;
    int   cycle_count    = 0;
    logic tx_idle_on     = 1'b0;
    logic rx_idle_on     = 1'b0;
    logic long_hold_req  = 1'b0;

    http_request_head_tokenizer uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    function automatic void want_token(logic [2:0] kind, logic [7:0] ch, logic first,
                                       logic [2:0] status, logic done);
        out_item_t t;
        t.token_kind  = kind;
        t.token_char  = ch;
        t.token_first = first;
        t.head_status = status;
        t.head_done   = done;
        pending_tokens.push_back(t);
    endfunction

    // one character of the current token, first flag from the token state
    function automatic void want_char(logic [2:0] kind, logic [7:0] ch);
        want_token(kind, ch, !tok_started, ST_OK, 1'b0);
        tok_started = 1'b1;
    endfunction

    // status item closes the head, later bytes are dropped until end_of_head
    function automatic void close_head(logic [2:0] status);
        want_token(K_STATUS, 8'h00, 1'b0, status, 1'b1);
        parse_ph = PH_DONE;
        if (status == ST_OK)
            heads_ok++;
        else
            heads_bad++;
    endfunction

    function automatic void restart_head();
        parse_ph     = PH_METHOD;
        cr_held      = 1'b0;
        tok_started  = 1'b0;
        line_started = 1'b0;
        qmark_seen   = 1'b0;
    endfunction

    function automatic void take_content(logic [7:0] c);
        case (parse_ph)
            PH_METHOD:
                if (c == CH_SP)
                begin
                    parse_ph    = PH_PATH;
                    tok_started = 1'b0;
                end
                else
                    want_char(K_METHOD, (c >= "a" && c <= "z") ? c - 8'd32 : c);
            PH_PATH:
                if (c == CH_SP)
                begin
                    parse_ph    = PH_PROTOCOL;
                    tok_started = 1'b0;
                end
                else if (c == CH_QMARK && tok_started && !qmark_seen)
                begin
                    // query marker after a path character opens the query
                    parse_ph    = PH_QUERY;
                    qmark_seen  = 1'b1;
                    tok_started = 1'b0;
                    want_char(K_QUERY, c);
                end
                else
                begin
                    // a leading marker stays in the path and blocks any query
                    if (c == CH_QMARK)
                        qmark_seen = 1'b1;
                    want_char(K_PATH, c);
                end
            PH_QUERY:
                if (c == CH_SP)
                begin
                    parse_ph    = PH_PROTOCOL;
                    tok_started = 1'b0;
                end
                else
                    want_char(K_QUERY, c);
            PH_PROTOCOL:
                want_char(K_PROTOCOL, (c >= "a" && c <= "z") ? c - 8'd32 : c);
            PH_KEY:
            begin
                line_started = 1'b1;
                if (c == CH_COLON)
                begin
                    parse_ph    = PH_VALUE;
                    tok_started = 1'b0;
                end
                else
                    want_char(K_KEY, (c >= "A" && c <= "Z") ? c + 8'd32 : c);
            end
            PH_VALUE:
            begin
                line_started = 1'b1;
                want_char(K_VALUE, c);
            end
            default:
                ;
        endcase
    endfunction

    function automatic void take_line_end();
        case (parse_ph)
            PH_METHOD, PH_PATH, PH_QUERY:
                close_head(ST_NO_START_SPACE);
            PH_PROTOCOL, PH_VALUE:
            begin
                want_token(K_LINE_END, 8'h00, 1'b0, ST_OK, 1'b0);
                parse_ph     = PH_KEY;
                tok_started  = 1'b0;
                line_started = 1'b0;
                qmark_seen   = 1'b0;
            end
            PH_KEY:
                if (!line_started)
                begin
                    // empty line: line end, then the ok status
                    want_token(K_LINE_END, 8'h00, 1'b0, ST_OK, 1'b0);
                    close_head(ST_OK);
                end
                else
                    close_head(ST_NO_COLON);
            default:
                ;
        endcase
    endfunction

    // token items caused by one accepted byte
    function automatic void predict_tokens(logic [7:0] b, logic eoh);
        if (parse_ph != PH_DONE)
        begin
            if (cr_held)
            begin
                cr_held = 1'b0;
                if (b == CH_LF)
                    take_line_end();
                else
                begin
                    // lone cr goes out as content ahead of this byte
                    take_content(CH_CR);
                    if (b == CH_CR)
                        cr_held = 1'b1;
                    else
                        take_content(b);
                end
            end
            else if (b == CH_CR)
                cr_held = 1'b1;
            else
                take_content(b);
        end
        if (eoh)
        begin
            // early end, a held cr is simply dropped
            if (parse_ph != PH_DONE)
                close_head((parse_ph <= PH_PROTOCOL) ? ST_NO_START_NEWLINE
                                                      : ST_NO_HEADER_NEWLINE);
            restart_head();
        end
    endfunction

    // ------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic eoh);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= {b, eoh};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        predict_tokens(b, eoh);
        bytes_sent++;
    endtask

    task automatic send_text(input string s, input logic eoh_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eoh_last && i == s.len() - 1);
    endtask

    // end_of_head rides on the last byte of the head
    task automatic send_head(input byte_q_t bytes);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // drop valid, then let every owed token item come out
    task automatic wait_all_tokens();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly letters, with markers, lone cr and any byte mixed in
    function automatic logic [7:0] random_text_byte();
        case ($urandom_range(0, 11))
            0:       return 8'($urandom_range(0, 255));
            1:       return CH_CR;
            2:       return CH_QMARK;
            3:       return CH_COLON;
            4:       return "/";
            5, 6, 7: return 8'($urandom_range(65, 90));
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    // a well-formed head with random content, or noise, or a broken head
    function automatic byte_q_t random_head();
        byte_q_t q;
        int      style;
        int      cut;
        style = $urandom_range(0, 9);
        if (style == 0)
        begin
            repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        repeat ($urandom_range(0, 4)) q.push_back(random_text_byte());
        q.push_back(CH_SP);
        repeat ($urandom_range(0, 5)) q.push_back(random_text_byte());
        q.push_back(CH_SP);
        repeat ($urandom_range(0, 4)) q.push_back(random_text_byte());
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        repeat ($urandom_range(0, 3))
        begin
            repeat ($urandom_range(0, 4)) q.push_back(random_text_byte());
            q.push_back(CH_COLON);
            repeat ($urandom_range(0, 6))
                q.push_back(($urandom_range(0, 4) == 0) ? CH_SP : random_text_byte());
            q.push_back(CH_CR);
            q.push_back(CH_LF);
        end
        q.push_back(CH_CR);
        q.push_back(CH_LF);
        case (style)
            1:
            begin
                // truncated head
                cut = $urandom_range(1, q.size());
                while (q.size() > cut)
                    void'(q.pop_back());
            end
            2:
                // one byte missing, often a space, colon or line end
                q.delete($urandom_range(0, q.size() - 1));
            3:
                // bytes past the end of the head
                repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
            default:
                ;
        endcase
        return q;
    endfunction

    // ------------------------------------------------------------------
    // token side
    // ------------------------------------------------------------------

    // random stall bursts, or one long hold on request
    initial
    begin : receiver
        int burst;
        token_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                token_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                token_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14);
                token_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                token_stall <= 1'b0;
            end
            else
                token_stall <= 1'b0;
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                errors++;
                $error("token item %h with none expected", token_item);
            end
            else
            begin
                token_want = pending_tokens.pop_front();
                tokens_checked++;
                check_field("token_kind", token_want.token_kind, token_item.token_kind);
                check_field("token_char", token_want.token_char, token_item.token_char);
                check_field("token_first", token_want.token_first, token_item.token_first);
                check_field("head_status", token_want.head_status, token_item.head_status);
                check_field("head_done", token_want.head_done, token_item.head_done);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("http_request_head_tokenizer_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // lone cr and lowercase in the method, byte extremes, leading query
        // marker kept in the path, early end on the start line
        send_text("\015a", 1'b0);
        send_byte(8'h00, 1'b0);
        send_text(" ?? ", 1'b0);
        send_byte(8'hff, 1'b1);
        // empty start line, then a byte after done that restarts
        send_text("\015\012", 1'b0);
        send_byte(8'h00, 1'b1);
        // empty method, query after a path character, uppercase key folded,
        // lone cr before the line end, empty line ends with ok
        send_text(" x?Q \015\012Ab:c\015\015\012\015\012", 1'b1);
        // empty path and protocol, header line without colon
        send_text("  \015\012K\015\012", 1'b1);
        // early end in a header line while a cr is held
        send_text("  \015\012\015", 1'b1);
        wait_all_tokens();
    endtask

    task automatic test_random_heads();
        int stop_at;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
            send_head(random_head());
        wait_all_tokens();
    endtask

    // receiver holds for a long stretch while bytes keep coming at full rate
    task automatic test_receiver_hold();
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        send_text("get /index?a=1 http/1.1\015\012Host: x\015\012\015\012", 1'b1);
        wait_all_tokens();
    endtask

    // sender stops after each head until all its token items are out
    task automatic test_paused_sender();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (3)
        begin
            send_head(random_head());
            wait_all_tokens();
        end
    endtask

    task automatic test_full_rate();
        int stop_at;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        stop_at = bytes_sent + FULL_RATE_BYTES;
        while (bytes_sent < stop_at)
            send_head(random_head());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        restart_head();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_heads();
        test_receiver_hold();
        test_paused_sender();
        test_full_rate();
        wait_all_tokens();

        $display("covered %0d bytes: %0d heads ended ok, %0d with an error status",
                 bytes_sent, heads_ok, heads_bad);
        $display("%0d token items checked under idling, a long hold and full rate",
                 tokens_checked);
        if (errors == 0)
            $display("http_request_head_tokenizer_tb: done, clean");
        else
            $display("http_request_head_tokenizer_tb: done, errors");
        $finish;
    end

endmodule
